@@ rtl/ir_voltage_to_distance_core_macros.svh @@
// ----------------------------------------------------------------------------
// ir_voltage_to_distance_core_macros: assertion macros
// Shared concurrent assertion forms clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef IR_VOLTAGE_TO_DISTANCE_CORE_MACROS_SVH
`define IR_VOLTAGE_TO_DISTANCE_CORE_MACROS_SVH

// Same-cycle implication.
`define IVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ivd_pkg.sv @@
// ----------------------------------------------------------------------------
// ivd_pkg: shared types and constants
// Item formats, curve coefficients, divider interface and back-end states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ivd_pkg;

  localparam int SEL_W      = 2;
  localparam int RAW_W      = 12;
  localparam int DIST_W     = 20;
  localparam int TABLE_ROWS = 3;

  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_QUO_W = 24;
  localparam int DIV_CNT_W = 5;

  localparam logic [DIV_CNT_W-1:0] K_T1 = 5'd24;
  localparam logic [DIV_CNT_W-1:0] K_T2 = 5'd23;

  // Reciprocals of 1000 for exact floor division by multiply and shift.
  // RECIP_V is ceil(2^38 / 1000) for dividends below 2^28.
  // RECIP_MM is ceil(2^31 / 1000) for dividends below 2^21.
  localparam logic [28:0] RECIP_V  = 29'd274877907;
  localparam logic [21:0] RECIP_MM = 22'd2147484;

  localparam logic [9:0]  V_ROUND   = 10'd500;
  localparam logic [13:0] SCALE_MM  = 14'd10;
  localparam logic [13:0] SCALE_UM  = 14'd10000;
  localparam logic [22:0] Q_MAX     = 23'h7FFFFF;
  localparam logic [DIST_W-1:0] DIST_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    REQ_SENSOR_MM = 2'd0,
    REQ_SENSOR_UM = 2'd1,
    REQ_ROBOT_UM  = 2'd2,
    REQ_ROBOT_MM  = 2'd3
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [SEL_W-1:0] sel;
    logic [RAW_W-1:0] raw;
    req_t             req;
  } job_t;

  // Signed members (c, e, cf) are two's complement.
  typedef struct packed {
    logic [20:0] a;
    logic [16:0] b;
    logic [18:0] c;
    logic [16:0] d;
    logic [19:0] e;
    logic [20:0] af;
    logic [16:0] bf;
    logic [19:0] cf;
    logic [15:0] offset_um;
  } coef_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_V, S_T1, S_T2, S_SUM, S_CONV, S_SCALE, S_MM, S_DONE
  } back_state_t;

  function automatic coef_t coef_lookup(input logic [SEL_W-1:0] sel);
    coef_t r;
    case (sel)
      2'd1: begin
        r = '{a: 21'd887036, b: 17'd13664, c: -19'sd113030, d: 17'd13684,
              e: -20'sd203450, af: 21'd1216099, bf: 17'd38201, cf: -20'sd299926,
              offset_um: 16'd33300};
      end
      2'd2: begin
        r = '{a: 21'd1023823, b: 17'd17164, c: -19'sd146761, d: 17'd17151,
              e: -20'sd265257, af: 21'd1456728, bf: 17'd46439, cf: -20'sd382796,
              offset_um: 16'd54100};
      end
      default: begin
        r = '{a: 21'd902136, b: 17'd17623, c: -19'sd111811, d: 17'd17610,
              e: -20'sd212186, af: 21'd1109465, bf: 17'd36844, cf: -20'sd272223,
              offset_um: 16'd33300};
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ivd_fifo.sv @@
// ----------------------------------------------------------------------------
// ivd_fifo: two-entry job queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ivd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ivd_pkg::job_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output ivd_pkg::job_t rd_data,
  output logic          empty
);

  ivd_pkg::job_t mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ wr_en;
    rptr_nxt = rptr_r ^ rd_en;
    cnt_nxt  = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/ivd_div.sv @@
// ----------------------------------------------------------------------------
// ivd_div: shared radix-2 restoring divider
// Produces an nbits-wide unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ivd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ivd_pkg::div_req_t req,
  output ivd_pkg::div_rsp_t rsp
);

  localparam int NW = ivd_pkg::DIV_NUM_W;
  localparam int DW = ivd_pkg::DIV_DEN_W;
  localparam int QW = ivd_pkg::DIV_QUO_W;
  localparam int CW = ivd_pkg::DIV_CNT_W;

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, den_r;
  logic [NW-1:0] num_r;
  logic [QW-1:0] quo_r;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   rem_step;

  // The quotient is known to fit in nbits, so the top part of the
  // dividend is already below the divisor and seeds the remainder.
  always_comb begin
    trial    = {rem_r, num_r[NW-1]};
    ge       = (trial >= {1'b0, den_r});
    rem_step = ge ? (trial - {1'b0, den_r}) : trial;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DW'(req.num >> req.nbits);
      num_r <= req.num << (6'(NW) - {1'b0, req.nbits});
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= rem_step[DW-1:0];
      num_r <= {num_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

endmodule

@@ rtl/ivd_front.sv @@
// ----------------------------------------------------------------------------
// ivd_front: input acceptance and classification
// Unpacks each input item, checks the sensor number and queues a job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ivd_front #(
  parameter int NUM_SENSORS = 3
) (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,
  input  logic [3:0]    in_tuser,
  input  logic          fifo_full,
  output logic          push,
  output ivd_pkg::job_t job
);

  logic [1:0] sel;

  assign sel       = in_tuser[1:0];
  assign in_tready = !fifo_full;
  assign push      = in_tvalid && !fifo_full;

  always_comb begin
    job.valid = (int'(sel) < NUM_SENSORS) && (int'(sel) < ivd_pkg::TABLE_ROWS)
                && (in_tdata[15:12] == 4'd0 || in_tdata[15:12] != 4'd0);
    job.sel   = sel;
    job.raw   = in_tdata[11:0];
    job.req   = ivd_pkg::req_t'(in_tuser[3:2]);
  end

endmodule

@@ rtl/ivd_back.sv @@
// ----------------------------------------------------------------------------
// ivd_back: curve evaluation and unit conversion
// Sequences the shared divider through the fit and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ir_voltage_to_distance_core_macros.svh"

module ivd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fast,
  input  logic              fifo_empty,
  input  ivd_pkg::job_t     fifo_rd_data,
  output logic              fifo_pop,
  output ivd_pkg::div_req_t div_req,
  input  ivd_pkg::div_rsp_t div_rsp,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic [0:0]        out_tuser
);

  ivd_pkg::back_state_t state_r, state_nxt;
  ivd_pkg::job_t        job_r, job_nxt;
  ivd_pkg::coef_t       coef_r, coef_nxt;
  logic [18:0]          v_r, v_nxt;
  logic [19:0]          dd_r, dd_nxt;
  logic [39:0]          sq_r, sq_nxt;
  logic [23:0]          t1_r, t1_nxt;
  logic [24:0]          t2_r, t2_nxt;
  logic [22:0]          cm_r, cm_nxt;
  logic                 flag_r, flag_nxt;
  logic [36:0]          prod_r, prod_nxt;
  logic [21:0]          mmx_r, mmx_nxt;
  logic [19:0]          res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [19:0]          out_dist_r, out_dist_nxt;
  logic                 out_sat_r, out_sat_nxt;

  logic signed [26:0]   sum;
  logic [18:0]          cmag;
  logic [21:0]          um;
  logic [19:0]          v_ext;
  logic [27:0]          vx;
  logic [56:0]          vprod;
  logic [43:0]          mmprod;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    coef_nxt      = coef_r;
    v_nxt         = v_r;
    dd_nxt        = dd_r;
    sq_nxt        = {20'd0, dd_r} * {20'd0, dd_r};
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    cm_nxt        = cm_r;
    flag_nxt      = flag_r;
    prod_nxt      = prod_r;
    mmx_nxt       = mmx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_dist_nxt  = out_dist_r;
    out_sat_nxt   = out_sat_r;
    fifo_pop      = 1'b0;
    div_req       = '0;
    // The sample in Q3.16 volts, rounded, by reciprocal multiplication.
    vx            = {fifo_rd_data.raw, 16'd0} + {18'd0, ivd_pkg::V_ROUND};
    vprod         = {29'd0, vx} * {28'd0, ivd_pkg::RECIP_V};
    mmprod        = {22'd0, mmx_r} * {22'd0, ivd_pkg::RECIP_MM};
    v_ext         = {1'b0, v_r};
    cmag          = coef_r.c[18] ? (~coef_r.c + 19'd1) : coef_r.c;
    sum = $signed({3'b000, t1_r}) + $signed({{2{t2_r[24]}}, t2_r})
        + $signed({{7{fast ? coef_r.cf[19] : coef_r.e[19]}}, fast ? coef_r.cf : coef_r.e});
    um  = {1'b0, prod_r[36:16]}
        + ((job_r.req == ivd_pkg::REQ_ROBOT_UM || job_r.req == ivd_pkg::REQ_ROBOT_MM)
           ? {6'd0, coef_r.offset_um} : 22'd0);

    case (state_r)
      ivd_pkg::S_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop = 1'b1;
          job_nxt  = fifo_rd_data;
          coef_nxt = ivd_pkg::coef_lookup(fifo_rd_data.sel);
          flag_nxt = 1'b0;
          if (!fifo_rd_data.valid) begin
            res_nxt   = '0;
            state_nxt = ivd_pkg::S_DONE;
          end else begin
            v_nxt     = vprod[56:38];
            state_nxt = ivd_pkg::S_V;
          end
        end
      end
      ivd_pkg::S_V: begin
        dd_nxt        = v_ext + {3'd0, coef_r.d};
        div_req.start = 1'b1;
        div_req.num   = {13'd0, fast ? coef_r.af : coef_r.a, 16'd0};
        div_req.den   = {20'd0, v_ext + {3'd0, fast ? coef_r.bf : coef_r.b}};
        div_req.nbits = ivd_pkg::K_T1;
        state_nxt     = ivd_pkg::S_T1;
      end
      ivd_pkg::S_T1: begin
        if (div_rsp.done) begin
          t1_nxt = div_rsp.quo;
          if (fast) begin
            t2_nxt    = '0;
            state_nxt = ivd_pkg::S_SUM;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = {cmag[17:0], 32'd0};
            div_req.den   = sq_r;
            div_req.nbits = ivd_pkg::K_T2;
            state_nxt     = ivd_pkg::S_T2;
          end
        end
      end
      ivd_pkg::S_T2: begin
        if (div_rsp.done) begin
          t2_nxt    = coef_r.c[18] ? (25'd0 - {1'b0, div_rsp.quo}) : {1'b0, div_rsp.quo};
          state_nxt = ivd_pkg::S_SUM;
        end
      end
      ivd_pkg::S_SUM: begin
        if (sum > $signed({4'd0, ivd_pkg::Q_MAX})) begin
          cm_nxt   = ivd_pkg::Q_MAX;
          flag_nxt = 1'b1;
        end else if (sum < 0) begin
          cm_nxt   = '0;
          flag_nxt = 1'b1;
        end else begin
          cm_nxt = sum[22:0];
        end
        state_nxt = ivd_pkg::S_CONV;
      end
      ivd_pkg::S_CONV: begin
        prod_nxt = {14'd0, cm_r} * {23'd0, (job_r.req == ivd_pkg::REQ_SENSOR_MM)
                                          ? ivd_pkg::SCALE_MM : ivd_pkg::SCALE_UM};
        state_nxt = ivd_pkg::S_SCALE;
      end
      ivd_pkg::S_SCALE: begin
        if (job_r.req == ivd_pkg::REQ_ROBOT_MM) begin
          mmx_nxt   = um + {12'd0, ivd_pkg::V_ROUND};
          state_nxt = ivd_pkg::S_MM;
        end else begin
          if (um > {2'd0, ivd_pkg::DIST_MAX}) begin
            res_nxt  = ivd_pkg::DIST_MAX;
            flag_nxt = 1'b1;
          end else begin
            res_nxt = um[19:0];
          end
          state_nxt = ivd_pkg::S_DONE;
        end
      end
      ivd_pkg::S_MM: begin
        // Rounded mm stays far below the distance limit.
        res_nxt   = {7'd0, mmprod[43:31]};
        state_nxt = ivd_pkg::S_DONE;
      end
      ivd_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_r;
          out_sat_nxt   = flag_r;
          state_nxt     = ivd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ivd_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_dist_r};
  assign out_tuser  = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ivd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    coef_r     <= coef_nxt;
    v_r        <= v_nxt;
    dd_r       <= dd_nxt;
    sq_r       <= sq_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    cm_r       <= cm_nxt;
    flag_r     <= flag_nxt;
    prod_r     <= prod_nxt;
    mmx_r      <= mmx_nxt;
    res_r      <= res_nxt;
    out_dist_r <= out_dist_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  `IVD_ASSERT_NOW(a_done_in_wait, div_rsp.done, state_r == ivd_pkg::S_T1 || state_r == ivd_pkg::S_T2, "divider finished outside a wait state")
  `IVD_ASSERT_NOW(a_pop_idle, fifo_pop, state_r == ivd_pkg::S_IDLE && !fifo_empty, "job popped outside idle")
  `IVD_ASSERT_NEXT(a_done_loads, state_r == ivd_pkg::S_DONE && !out_valid_r, out_valid_r && state_r == ivd_pkg::S_IDLE, "finished result not loaded")

endmodule

@@ rtl/ir_voltage_to_distance_core.sv @@
// ----------------------------------------------------------------------------
// ir_voltage_to_distance_core: infrared range sensor linearizer
// Converts raw sensor samples into distances with per-sensor fitted curves.
// ----------------------------------------------------------------------------
// Each input item carries a 12-bit sample in millivolts, a sensor number and
// a request kind; each produces exactly one result item holding the distance
// in sensor mm, sensor um, robot um or rounded robot mm, plus a flag that is
// set whenever the value was clamped at zero or at the top of its range.
// Sensor numbers at or above NUM_SENSORS (or the unused code 3) give a zero
// distance with the flag clear. The front end accepts items into a two-entry
// queue while the back end works, so input and output stall independently.
// Arithmetic keeps 16 fraction bits: the sample is Q3.16 volts and the
// signed curve sum is clamped to unsigned Q7.16. The fixed divisions by 1000
// use reciprocal multiplies; the curve terms run on one shared bit-serial
// divider (quotients of 24 and 23 bits; the fast fit uses only the first).
// Robot mm adds a rounding step; bad sensor numbers skip the curve. The back
// end finishes each item before taking the next; a stalled output holds it.
// Setting cfg_wr_en writes the fast_formula bit; write it only while no item
// is in flight. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_voltage_to_distance_core #(
  parameter int NUM_SENSORS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item: tdata = raw_sample[11:0], zeros[15:12].
  // tuser = sensor_select[1:0], req_type[3:2].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [3:0]  in_tuser,
  // Result item: tdata = distance[19:0], zeros[23:20]. tuser = saturated[0].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [0:0]  out_tuser,
  // Configuration: fast_formula.
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_wr_data
);

  logic              fast_r, fast_nxt;
  logic              push;
  logic              fifo_full;
  logic              fifo_empty;
  logic              fifo_pop;
  ivd_pkg::job_t     job_in;
  ivd_pkg::job_t     job_out;
  ivd_pkg::div_req_t div_req;
  ivd_pkg::div_rsp_t div_rsp;

  // The fit selection register holds across items.
  assign fast_nxt = cfg_wr_en ? cfg_wr_data[0] : fast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r <= 1'b0;
    end else begin
      fast_r <= fast_nxt;
    end
  end

  ivd_front #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_full (fifo_full),
    .push      (push),
    .job       (job_in)
  );

  ivd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (job_in),
    .full    (fifo_full),
    .rd_en   (fifo_pop),
    .rd_data (job_out),
    .empty   (fifo_empty)
  );

  ivd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ivd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fast         (fast_r),
    .fifo_empty   (fifo_empty),
    .fifo_rd_data (job_out),
    .fifo_pop     (fifo_pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule
